// File: design/lmcfw_pkg.sv
// shared types and constants for the led matrix cascade frame writer
`default_nettype none

package lmcfw_pkg;

  // input mode codes
  localparam logic [1:0] ModePixel = 2'd0;
  localparam logic [1:0] ModeRow   = 2'd1;
  localparam logic [1:0] ModeBcast = 2'd2;

  localparam int StoreDepth = 32;
  localparam int QueueDepth = 2;
  localparam logic [7:0] MsbMask = 8'h80;

  typedef enum logic [1:0] {
    KindPixel,
    KindRow,
    KindBcast
  } kind_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] led_row;
    logic [4:0] column;
    logic [4:0] row_line;
    logic [7:0] value;
    logic [3:0] cmd_address;
  } item_t;

  typedef struct packed {
    logic [3:0] reg_address;
    logic [7:0] reg_data;
    logic       frame_end;
    logic       run_last;
  } result_t;

  // one classified job for the back end
  typedef struct packed {
    kind_e      kind;
    logic [2:0] led_row;
    logic [4:0] column;
    logic [7:0] value;
    logic [3:0] cmd_address;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/lmcfw_front.sv
// front end: takes items, drops those without output, builds back end jobs
`default_nettype none

module lmcfw_front
  import lmcfw_pkg::*;
#(
  parameter int DEVICES = 4
) (
  input  var logic  accept_i,
  input  var item_t item_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  localparam int Limit = (8 * DEVICES < StoreDepth) ? 8 * DEVICES : StoreDepth;
  localparam logic [5:0] LimitW = 6'(Limit);

  logic col_ok;
  logic line_ok;

  assign col_ok  = {1'b0, item_i.column} < LimitW;
  assign line_ok = {1'b0, item_i.row_line} < LimitW;

  always_comb begin
    push_o            = 1'b0;
    cmd_o.kind        = KindPixel;
    cmd_o.led_row     = item_i.led_row;
    cmd_o.column      = item_i.column;
    cmd_o.value       = item_i.value;
    cmd_o.cmd_address = item_i.cmd_address;
    case (item_i.mode)
      ModePixel: begin
        push_o = accept_i && col_ok;
      end
      ModeRow: begin
        // start at the highest column of the device, led row from the line
        push_o        = accept_i && line_ok;
        cmd_o.kind    = KindRow;
        cmd_o.led_row = item_i.row_line[2:0];
        cmd_o.column  = {item_i.row_line[4:3], 3'b111};
      end
      ModeBcast: begin
        push_o     = accept_i;
        cmd_o.kind = KindBcast;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/lmcfw_queue.sv
// short job queue between front and back end
`default_nettype none

module lmcfw_queue
  import lmcfw_pkg::*;
(
  input  var logic clk_i,
  input  var logic rst_ni,
  input  var logic push_i,
  input  var cmd_t cmd_i,
  output logic     full_o,
  output logic     valid_o,
  output cmd_t     cmd_o,
  input  var logic pop_i
);

  localparam int PtrW = $clog2(QueueDepth);

  cmd_t           entry_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [PtrW:0]   count_q, count_d;

  assign full_o  = count_q == (PtrW + 1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign cmd_o   = entry_q[rd_q];

  always_comb begin
    wr_d    = push_i ? wr_q + 1'b1 : wr_q;
    rd_d    = pop_i ? rd_q + 1'b1 : rd_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: design/lmcfw_back.sv
// back end: column store and word sequencer, one device word per cycle while a job runs
`default_nettype none

module lmcfw_back
  import lmcfw_pkg::*;
#(
  parameter int DEVICES = 4
) (
  input  var logic clk_i,
  input  var logic rst_ni,
  input  var logic cmd_valid_i,
  input  var cmd_t cmd_i,
  output logic     pop_o,
  output logic     result_valid_o,
  output result_t  result_o
);

  localparam int WordW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam logic [WordW-1:0] LastWord = WordW'(DEVICES - 1);

  logic [7:0]       store_q [StoreDepth];
  logic             active_q;
  logic             valid_q;
  logic [WordW-1:0] word_q;
  kind_e            kind_q;
  logic [2:0]       led_row_q;
  logic [4:0]       col_q;
  logic [7:0]       value_q;
  logic [3:0]       addr_q;
  result_t          result_q;

  logic [7:0]       cur_byte;
  logic [7:0]       mask;
  logic [7:0]       new_byte;
  logic             pix_on;
  logic             frame_last;
  logic             run_end;
  logic             load;
  logic [WordW-1:0] target;
  result_t          word;

  always_comb begin
    cur_byte   = store_q[col_q];
    mask       = 8'd1 << led_row_q;
    pix_on     = (kind_q == KindPixel) ? (value_q != 8'd0) : ((value_q & MsbMask) != 8'd0);
    new_byte   = pix_on ? (cur_byte | mask) : (cur_byte & ~mask);
    frame_last = word_q == LastWord;
    // a row job ends after the frame for the lowest column of its device
    run_end    = active_q && frame_last && (kind_q != KindRow || col_q[2:0] == 3'd0);
    target     = LastWord - WordW'(col_q[4:3]);
    word.frame_end = frame_last;
    word.run_last  = run_end;
    if (kind_q == KindBcast) begin
      word.reg_address = addr_q;
      word.reg_data    = value_q;
    end else if (word_q == target) begin
      word.reg_address = {1'b0, col_q[2:0]} + 4'd1;
      word.reg_data    = new_byte;
    end else begin
      word.reg_address = 4'd0;
      word.reg_data    = 8'd0;
    end
  end

  assign load  = cmd_valid_i && (!active_q || run_end);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      word_q   <= '0;
      for (int i = 0; i < StoreDepth; i++) begin
        store_q[i] <= 8'd0;
      end
    end else begin
      valid_q <= active_q;
      if (active_q && kind_q != KindBcast && word_q == '0) begin
        store_q[col_q] <= new_byte;
      end
      if (load) begin
        active_q <= 1'b1;
        word_q   <= '0;
      end else if (active_q) begin
        if (frame_last) begin
          word_q <= '0;
          if (run_end) begin
            active_q <= 1'b0;
          end
        end else begin
          word_q <= word_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (active_q) begin
      result_q <= word;
    end
    if (load) begin
      kind_q    <= cmd_i.kind;
      led_row_q <= cmd_i.led_row;
      col_q     <= cmd_i.column;
      value_q   <= cmd_i.value;
      addr_q    <= cmd_i.cmd_address;
    end else if (active_q && frame_last && !run_end) begin
      // next column down and next value bit
      col_q[2:0] <= col_q[2:0] - 3'd1;
      value_q    <= value_q << 1;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire

// File: design/led_matrix_cascade_frame_writer_top.sv
// top level of the led matrix cascade frame writer
`default_nettype none

// frame writer for a daisy chain of DEVICES 8x8 led matrix drivers
// - command channel: item_i is taken on a rising edge with start high and busy low
// - result channel: one device word per cycle on result_o while a job runs, marked by result_valid_o;
//   each word is a transfer at the edge that ends its cycle, the receiver cannot stall
// - pixel mode gives one chain frame of DEVICES words, broadcast mode one frame,
//   row mode eight frames (8*DEVICES words); out of range items and mode 3 give none
// - the first word passes through the queue, the back end job registers and the result register
// - the back end emits one word per cycle while it holds a job: a row item fills
//   8*DEVICES words, a pixel or broadcast item DEVICES words; jobs run back to back with no gap
// - a two entry job queue sits between the front and back end; busy is high while
//   it is full, so the sustained rate is set by the back end word sequencer
// - reset clears the column store (all pixels off), the queue and the sequencer
module led_matrix_cascade_frame_writer_top
  import lmcfw_pkg::*;
#(
  parameter int DEVICES = 4
) (
  input  var logic  clk_i,
  input  var logic  rst_ni,
  input  var logic  start,
  output logic      busy,
  input  var item_t item_i,
  output logic      result_valid_o,
  output result_t   result_o
);

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  // items are accepted whenever the queue has room
  assign busy   = q_full;
  assign accept = start && !q_full;

  lmcfw_front #(
    .DEVICES (DEVICES)
  ) u_front (
    .accept_i (accept),
    .item_i   (item_i),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  lmcfw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (pop)
  );

  // back end pulls the next job on the last word of the current one
  lmcfw_back #(
    .DEVICES (DEVICES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_cmd),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

// File: tb/lmcfw_word_checker.sv
// watches the frame writer channels, predicts the device words and compares them
module lmcfw_word_checker
  import lmcfw_pkg::*;
#(
  parameter int DEVICES = 4
) (
  input  var logic    clk_i,
  input  var logic    rst_ni,
  input  var logic    start,
  input  var logic    busy,
  input  var item_t   item_i,
  input  var logic    result_valid_o,
  input  var result_t result_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          words_o
);

  localparam int ChainColumns = 8 * DEVICES;

  logic [7:0] column_bytes [StoreDepth];
  result_t    awaited_words [$];

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    words_o = 0;
  end

  task automatic push_word(input logic [3:0] addr, input logic [7:0] data, input logic fend);
    result_t w;
    w.reg_address = addr;
    w.reg_data = data;
    w.frame_end = fend;
    w.run_last = 1'b0;
    awaited_words.push_back(w);
  endtask

  // one pixel write followed by its chain frame, farthest device first
  task automatic pixel_frame(input logic [2:0] bit_row, input logic [4:0] col, input logic on);
    int dev;
    logic [3:0] digit;
    dev = col / 8;
    digit = 4'(col % 8 + 1);
    column_bytes[col][bit_row] = on;
    for (int i = 0; i < DEVICES; i++) begin
      if (i == DEVICES - 1 - dev) begin
        push_word(digit, column_bytes[col], i == DEVICES - 1);
      end else begin
        push_word(4'd0, 8'd0, i == DEVICES - 1);
      end
    end
  endtask

  task automatic predict_device_words(input item_t it);
    int count_before;
    logic [4:0] col;
    logic [7:0] bits;
    result_t tail;
    count_before = awaited_words.size();
    case (it.mode)
      ModePixel: begin
        if (it.column < ChainColumns) pixel_frame(it.led_row, it.column, it.value != 8'd0);
      end
      ModeRow: begin
        if (it.row_line < ChainColumns) begin
          bits = it.value;
          for (int j = 0; j < 8; j++) begin
            col = 5'(8 * (it.row_line / 8) + 7 - j);
            pixel_frame(it.row_line[2:0], col, bits[7]);
            bits = bits << 1;
          end
        end
      end
      ModeBcast: begin
        for (int i = 0; i < DEVICES; i++) push_word(it.cmd_address, it.value, i == DEVICES - 1);
      end
      default: ;
    endcase
    if (awaited_words.size() > count_before) begin
      tail = awaited_words.pop_back();
      tail.run_last = 1'b1;
      awaited_words.push_back(tail);
    end
  endtask

  task automatic compare_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      awaited_words.delete();
      foreach (column_bytes[i]) column_bytes[i] = 8'd0;
    end else begin
      // words leaving now belong to earlier commands, so check before predicting
      if (result_valid_o) begin
        if (awaited_words.size() == 0) begin
          $error("unexpected device word: reg_address %0h reg_data %0h",
                 result_o.reg_address, result_o.reg_data);
          fail_count_o++;
        end else begin
          want = awaited_words.pop_front();
          compare_field("reg_address", 8'(want.reg_address), 8'(result_o.reg_address));
          compare_field("reg_data", want.reg_data, result_o.reg_data);
          compare_field("frame_end", 8'(want.frame_end), 8'(result_o.frame_end));
          compare_field("run_last", 8'(want.run_last), 8'(result_o.run_last));
          words_o++;
        end
      end
      if (start && !busy) predict_device_words(item_i);
    end
    pending_o = awaited_words.size();
  end

endmodule

// File: tb/tb_led_matrix_cascade_frame_writer_top.sv
// stimulus and verdict for the led matrix cascade frame writer
module tb_led_matrix_cascade_frame_writer_top;
  import lmcfw_pkg::*;

  localparam int Devices = 4;
  // mode code the block must ignore
  localparam logic [1:0] ModeUnused = 2'd3;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    result_valid_o;
  result_t result_o;

  int fail_count;
  int pending_words;
  int words_checked;
  int mode_tally [4];

  led_matrix_cascade_frame_writer_top #(
    .DEVICES(Devices)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // predicts every device word from the accepted commands and checks the output
  lmcfw_word_checker #(
    .DEVICES(Devices)
  ) word_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_words),
    .words_o       (words_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case a transfer never completes
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic item_t make_item(input logic [1:0] mode, input logic [2:0] led_row,
                                       input logic [4:0] column, input logic [4:0] row_line,
                                       input logic [7:0] value, input logic [3:0] cmd_address);
    item_t it;
    it.mode = mode;
    it.led_row = led_row;
    it.column = column;
    it.row_line = row_line;
    it.value = value;
    it.cmd_address = cmd_address;
    return it;
  endfunction

  // mostly pixel and broadcast traffic, a fair share of row writes, a little unused mode
  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = $urandom_range(99);
    it.mode = (pick < 40) ? ModePixel : (pick < 62) ? ModeRow : (pick < 90) ? ModeBcast
            : ModeUnused;
    it.led_row = 3'($urandom_range(7));
    it.column = 5'($urandom_range(31));
    it.row_line = 5'($urandom_range(31));
    // zero clears a pixel, so give it real weight
    it.value = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
    it.cmd_address = 4'($urandom_range(15));
    return it;
  endfunction

  // holds start high from a falling edge until a rising edge sees busy low
  task automatic send_item(input item_t it);
    start <= 1'b1;
    item_i <= it;
    mode_tally[it.mode]++;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // random sender gap, sometimes long enough to let the back end run dry
  task automatic maybe_pause(input bit allowed);
    int gap;
    if (allowed && $urandom_range(99) < 29) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
      start <= 1'b0;
      item_i <= random_item();
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // sender holds off until every predicted word has come out
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_words != 0);
  endtask

  initial begin
    foreach (mode_tally[i]) mode_tally[i] = 0;
    start = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: corner columns and rows, pixel set and clear, every mode
    send_item(make_item(ModePixel, 3'd0, 5'd0, 5'd31, 8'd1, 4'd15));
    send_item(make_item(ModePixel, 3'd7, 5'd31, 5'd0, 8'd255, 4'd0));
    send_item(make_item(ModePixel, 3'd7, 5'd31, 5'd31, 8'd0, 4'd15));
    send_item(make_item(ModePixel, 3'd3, 5'd8, 5'd0, 8'h80, 4'd0));
    send_item(make_item(ModePixel, 3'd5, 5'd23, 5'd0, 8'h01, 4'd0));
    // clearing a pixel that was never set
    send_item(make_item(ModePixel, 3'd0, 5'd7, 5'd0, 8'd0, 4'd0));
    send_item(make_item(ModeRow, 3'd7, 5'd31, 5'd0, 8'hA5, 4'd15));
    send_item(make_item(ModeRow, 3'd0, 5'd0, 5'd31, 8'hFF, 4'd0));
    send_item(make_item(ModeRow, 3'd0, 5'd0, 5'd15, 8'h00, 4'd0));
    send_item(make_item(ModeRow, 3'd2, 5'd3, 5'd24, 8'h5A, 4'd9));
    // row writes must show up in the column bytes that a later pixel frame carries
    send_item(make_item(ModePixel, 3'd1, 5'd26, 5'd0, 8'd0, 4'd0));
    send_item(make_item(ModePixel, 3'd7, 5'd0, 5'd0, 8'd2, 4'd0));
    send_item(make_item(ModeBcast, 3'd7, 5'd31, 5'd31, 8'hFF, 4'd15));
    send_item(make_item(ModeBcast, 3'd0, 5'd0, 5'd0, 8'h00, 4'd0));
    send_item(make_item(ModeBcast, 3'd5, 5'd10, 5'd21, 8'h5A, 4'hA));
    // unused mode must produce nothing, with all other fields high or low
    send_item(make_item(ModeUnused, 3'd7, 5'd31, 5'd31, 8'hFF, 4'd15));
    send_item(make_item(ModeUnused, 3'd0, 5'd0, 5'd0, 8'h00, 4'd0));
    send_item(make_item(ModePixel, 3'd4, 5'd16, 5'd0, 8'h10, 4'd0));
    drain();

    // random traffic: a window with no sender gaps, and one full drain after 200 items
    for (int n = 0; n < 280; n++) begin
      if (n == 200) drain();
      send_item(random_item());
      maybe_pause(!(n >= 60 && n < 140));
    end

    drain();
    repeat (40) @(negedge clk_i);

    $display("covered %0d pixel, %0d row, %0d broadcast and %0d unused-mode commands",
             mode_tally[ModePixel], mode_tally[ModeRow], mode_tally[ModeBcast],
             mode_tally[ModeUnused]);
    $display("%0d device words checked against the predicted chain frames", words_checked);
    if (fail_count == 0 && pending_words == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
